>>> src/mspb_pkg.sv
// mspb_pkg: shared types and constants of the multichannel servo pwm burst block
// command codes, configuration register indexes, field widths and reset values
// no dependencies
package mspb_pkg;

	localparam int CmdW   = 2;
	localparam int ChanW  = 5;
	localparam int ValW   = 16;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;
	localparam int RepPins = 24;
	localparam int InDataW = 24;
	localparam int OutDataW = 32;

	typedef enum logic [CmdW-1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_START = 2'd2,
		CMD_LEVEL = 2'd3
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PERIOD = 2'd0,
		CFG_COUNT  = 2'd1,
		CFG_OFFSET = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	localparam logic [ValW-1:0]  PeriodRst = 16'd1000;
	localparam logic [ChanW-1:0] CountRst  = 5'd2;
	localparam logic [ChanW-1:0] OffsetRst = 5'd0;

endpackage

>>> src/mspb_mask.sv
// mspb_mask: per-channel width compares that build the pin raise and clear masks
// depends on mspb_pkg
module mspb_mask #(
	parameter int NUM_PINS = 24
) (
	input  logic [mspb_pkg::ValW-1:0]  widths [NUM_PINS],
	input  logic [mspb_pkg::ValW-1:0]  period_eff,
	input  logic [mspb_pkg::ChanW-1:0] chan_count,
	input  logic [mspb_pkg::ChanW-1:0] pin_off,
	input  logic [mspb_pkg::ValW-1:0]  tick_next,
	output logic [NUM_PINS-1:0]        raise_mask,
	output logic [NUM_PINS-1:0]        clear_mask
);
	import mspb_pkg::*;

	logic [NUM_PINS-1:0]   raise_ch;
	logic [NUM_PINS-1:0]   clear_ch;
	logic [2*NUM_PINS-1:0] raise_sh;
	logic [2*NUM_PINS-1:0] clear_sh;

	// channel vectors, one bit per channel
	always_comb begin
		logic [ValW-1:0] w;
		for (int c = 0; c < NUM_PINS; c++) begin
			w = (widths[c] > period_eff) ? period_eff : widths[c];
			raise_ch[c] = (c < int'(chan_count)) && (w != '0);
			clear_ch[c] = (c < int'(chan_count)) && (w != '0) && (w <= tick_next);
		end
	end

	// channel c drives pin offset + c, pins past the top fall off
	assign raise_sh = {{NUM_PINS{1'b0}}, raise_ch} << pin_off;
	assign clear_sh = {{NUM_PINS{1'b0}}, clear_ch} << pin_off;
	assign raise_mask = raise_sh[NUM_PINS-1:0];
	assign clear_mask = clear_sh[NUM_PINS-1:0];

endmodule

>>> src/multichannel_servo_pwm_burst.sv
// multichannel_servo_pwm_burst: top level of the pwm burst generator
// holds the item pipeline, burst state, width store and configuration registers
// depends on mspb_pkg and mspb_mask
//
// usage
//   s_* carries command items: s_tuser holds the command (tick, load width,
//   start burst, static pin level), s_tdata holds channel and value. every
//   accepted item produces exactly one result transfer on m_*, carrying the
//   24 reported pin levels, the busy flag and the burst-done flag.
//   cfg_* writes period_ticks (index 0), channel_count (1) and pin_offset (2);
//   other indexes are ignored. write configuration only while idle.
// timing
//   an item is registered in the input stage at its input transfer and
//   processed once the output register is free, when its result is loaded
//   into the output register, from which it can transfer. one item per
//   cycle sustained while m_tready stays high, set by the combinational
//   state update (parallel width compares).
// reset
//   arst_n clears all widths, pins, counters and the burst state, and loads
//   the configuration defaults (period 1000, two channels, offset zero).
// backpressure
//   when m_tready is low the result holds in the output register; one more
//   item may sit in the input register, then s_tready drops.
module multichannel_servo_pwm_burst #(
	parameter int NUM_PINS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item input
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mspb_pkg::InDataW-1:0]  s_tdata,   // channel[4:0], value[20:5], zero pad
	input  logic [mspb_pkg::CmdW-1:0]     s_tuser,   // command[1:0]
	// result output
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mspb_pkg::OutDataW-1:0] m_tdata,   // pins[23:0], busy_res[24], burst_done[25]
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mspb_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mspb_pkg::CfgDataW-1:0] cfg_data
);
	import mspb_pkg::*;

	localparam int RepW = (NUM_PINS < RepPins) ? NUM_PINS : RepPins;

	// configuration registers
	logic [ValW-1:0]  period_q;
	logic [ChanW-1:0] count_q;
	logic [ChanW-1:0] offset_q;

	// burst state
	logic [ValW-1:0]     width_q [NUM_PINS];
	logic [ValW-1:0]     tick_q;
	logic [ValW-1:0]     left_q;
	logic                run_q;
	logic [NUM_PINS-1:0] pins_q;

	// input stage
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [ChanW-1:0] chan_s1;
	logic [ValW-1:0]  val_s1;

	// result stage
	logic                valid_s2;
	logic [RepPins-1:0]  pins_s2;
	logic                busy_s2;
	logic                done_s2;

	logic                adv;
	logic [ValW-1:0]     period_eff;
	logic [ValW-1:0]     tick_inc;
	logic [ValW-1:0]     left_dec;
	logic [NUM_PINS-1:0] raise_mask;
	logic [NUM_PINS-1:0] clear_mask;
	logic [ValW-1:0]     nxt_tick;
	logic [ValW-1:0]     nxt_left;
	logic                nxt_run;
	logic [NUM_PINS-1:0] nxt_pins;
	logic                nxt_done;

	// output register frees when empty or taken
	assign adv       = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, done_s2, busy_s2, pins_s2};

	// a zero period acts as one tick
	assign period_eff = (period_q == '0) ? 16'd1 : period_q;
	assign tick_inc   = tick_q + 16'd1;
	assign left_dec   = left_q - 16'd1;

	mspb_mask #(
		.NUM_PINS(NUM_PINS)
	) u_mask (
		.widths    (width_q),
		.period_eff(period_eff),
		.chan_count(count_q),
		.pin_off   (offset_q),
		.tick_next (tick_inc),
		.raise_mask(raise_mask),
		.clear_mask(clear_mask)
	);

	// next burst state for the item in the input stage
	always_comb begin
		nxt_tick = tick_q;
		nxt_left = left_q;
		nxt_run  = run_q;
		nxt_pins = pins_q;
		nxt_done = 1'b0;
		unique case (cmd_s1)
			CMD_TICK: begin
				if (run_q) begin
					nxt_tick = tick_inc;
					nxt_pins = pins_q & ~clear_mask;
					if (tick_inc >= period_eff) begin
						// period ends: next period or end of burst
						nxt_tick = '0;
						nxt_left = left_dec;
						if (left_dec == '0) begin
							nxt_run  = 1'b0;
							nxt_done = 1'b1;
						end else begin
							nxt_pins = nxt_pins | raise_mask;
						end
					end
				end
			end
			CMD_LOAD: begin
				// width store is written in the clocked block
			end
			CMD_START: begin
				// ignored while running or with zero periods
				if (!run_q && val_s1 != '0) begin
					nxt_run  = 1'b1;
					nxt_left = val_s1;
					nxt_tick = '0;
					nxt_pins = pins_q | raise_mask;
				end
			end
			CMD_LEVEL: begin
				for (int p = 0; p < NUM_PINS; p++) begin
					if (32'(chan_s1) == 32'(p)) begin
						nxt_pins[p] = val_s1[0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PeriodRst;
			count_q  <= CountRst;
			offset_q <= OffsetRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PERIOD: period_q <= cfg_data;
				CFG_COUNT:  count_q  <= cfg_data[ChanW-1:0];
				CFG_OFFSET: offset_q <= cfg_data[ChanW-1:0];
				CFG_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= cmd_t'(s_tuser);
			chan_s1 <= s_tdata[ChanW-1:0];
			val_s1  <= s_tdata[ChanW +: ValW];
		end
	end

	// burst state and width store, updated as the item moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			left_q <= '0;
			run_q  <= 1'b0;
			pins_q <= '0;
			for (int i = 0; i < NUM_PINS; i++) begin
				width_q[i] <= '0;
			end
		end else if (valid_s1 && adv) begin
			tick_q <= nxt_tick;
			left_q <= nxt_left;
			run_q  <= nxt_run;
			pins_q <= nxt_pins;
			for (int i = 0; i < NUM_PINS; i++) begin
				if (cmd_s1 == CMD_LOAD && 32'(chan_s1) == 32'(i)) begin
					width_q[i] <= val_s1;
				end
			end
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// result stage payload, pins above the reported range are not shown
	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			pins_s2 <= RepPins'(nxt_pins[RepW-1:0]);
			busy_s2 <= nxt_run;
			done_s2 <= nxt_done;
		end
	end

	// a burst runs exactly while periods remain
	a_run_left: assert property (@(posedge clk) disable iff (!arst_n)
		run_q == (left_q != '0))
		else $error("running flag disagrees with remaining periods");

	// a result that ends a burst never reports busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> !busy_s2)
		else $error("burst done reported while busy");

	// an empty output register always lets an item in
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with an empty output register");

endmodule

>>> bench/multichannel_servo_pwm_burst_tb.sv
// multichannel_servo_pwm_burst_tb: self-checking bench for the pwm burst generator
// predicts every result from its own copy of widths, counters and pin levels
// depends on mspb_pkg and the multichannel_servo_pwm_burst rtl
module multichannel_servo_pwm_burst_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mspb_pkg::*;

	localparam int NPINS       = 24;
	localparam int HOLD_CYCLES = 60;    // long receiver hold-off, fills the block
	localparam int STALL_LIMIT = 2000;  // cycles with no transfer at all
	localparam int ITEM_GOAL   = 1450;

	// one result transfer, last field in the lowest bits
	typedef struct packed {
		logic            burst_done;
		logic            busy;
		logic [NPINS-1:0] pins;
	} pwm_result_t;

	// predictor of the burst generator plus the queue of results still owed
	class burst_scoreboard;
		logic [15:0]      period_reg;
		logic [4:0]       count_reg;
		logic [4:0]       offset_reg;
		logic [15:0]      width_mem [NPINS];
		logic [15:0]      tick_cnt;
		logic [15:0]      periods_rem;
		bit               active;
		logic [NPINS-1:0] pin_state;
		pwm_result_t      pending [$];
		int               errors;

		function new();
			period_reg  = PeriodRst;
			count_reg   = CountRst;
			offset_reg  = OffsetRst;
			foreach (width_mem[i]) width_mem[i] = '0;
			tick_cnt    = '0;
			periods_rem = '0;
			active      = 1'b0;
			pin_state   = '0;
			errors      = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] d);
			case (idx)
				CFG_PERIOD: period_reg = d;
				CFG_COUNT:  count_reg  = d[4:0];
				CFG_OFFSET: offset_reg = d[4:0];
				default: ;
			endcase
		endfunction

		// a zero period register acts as one tick
		function int eff_period();
			return (period_reg == 16'd0) ? 1 : int'(period_reg);
		endfunction

		// widths above the period saturate to it
		function int eff_width(int ch);
			int p;
			p = eff_period();
			return (int'(width_mem[ch]) > p) ? p : int'(width_mem[ch]);
		endfunction

		// pin driven by a channel, empty when the channel or its pin is out of range
		function logic [NPINS-1:0] pin_mask(int ch);
			logic [NPINS-1:0] m;
			int pin;
			m = '0;
			pin = int'(offset_reg) + ch;
			if (ch < int'(count_reg) && pin < NPINS)
				m[pin] = 1'b1;
			return m;
		endfunction

		function void raise_driven();
			for (int ch = 0; ch < NPINS; ch++)
				if (eff_width(ch) != 0) pin_state |= pin_mask(ch);
		endfunction

		function void clear_due();
			for (int ch = 0; ch < NPINS; ch++)
				if (eff_width(ch) != 0 && eff_width(ch) <= int'(tick_cnt))
					pin_state &= ~pin_mask(ch);
		endfunction

		// accepted input transfer: advance the state and queue the result
		function void note_item(cmd_t c, logic [4:0] ch, logic [15:0] v);
			pwm_result_t r;
			r.burst_done = 1'b0;
			case (c)
				CMD_TICK: if (active) begin
					tick_cnt = tick_cnt + 16'd1;
					clear_due();
					if (int'(tick_cnt) >= eff_period()) begin
						tick_cnt    = '0;
						periods_rem = periods_rem - 16'd1;
						if (periods_rem == 16'd0) begin
							active       = 1'b0;
							r.burst_done = 1'b1;
						end else begin
							raise_driven();
						end
					end
				end
				CMD_LOAD: if (ch < NPINS) width_mem[ch] = v;
				CMD_START: if (!active && v != 16'd0) begin
					active      = 1'b1;
					periods_rem = v;
					tick_cnt    = '0;
					raise_driven();
				end
				default: if (ch < NPINS) pin_state[ch] = v[0];
			endcase
			r.pins = pin_state;
			r.busy = active;
			pending.push_back(r);
		endfunction

		// accepted result transfer: compare with the oldest prediction
		function void check_result(logic [OutDataW-1:0] d);
			pwm_result_t got;
			pwm_result_t want;
			got = d[$bits(pwm_result_t)-1:0];
			if (pending.size() == 0) begin
				errors++;
				$display("%t: result with nothing pending, actual %h", $time, d);
				return;
			end
			want = pending.pop_front();
			if (got.pins !== want.pins) begin
				errors++;
				$display("%t: pins mismatch, expected %h, actual %h", $time, want.pins, got.pins);
			end
			if (got.busy !== want.busy) begin
				errors++;
				$display("%t: busy mismatch, expected %b, actual %b", $time, want.busy, got.busy);
			end
			if (got.burst_done !== want.burst_done) begin
				errors++;
				$display("%t: burst_done mismatch, expected %b, actual %b", $time,
					want.burst_done, got.burst_done);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;   // channel[4:0], value[20:5], zero pad
	logic [CmdW-1:0]     s_tuser;   // command[1:0]
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;   // pins[23:0], busy_res[24], burst_done[25]
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	burst_scoreboard sb;
	int  item_cnt     = 0;
	int  stall_cycles = 0;
	int  src_mode     = 1;   // 0 no gaps, 1 light gaps, 2 heavy gaps
	int  snk_mode     = 1;
	bit  quiet        = 1'b0; // final stretch: no idling on either side
	bit  hold_req     = 1'b0; // asks the receiver for one long hold-off

	multichannel_servo_pwm_burst #(
		.NUM_PINS(NPINS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// random choice of whether a side idles before its next transfer
	function automatic bit idle_now(int mode);
		if (quiet) return 1'b0;
		case (mode)
			0:       return 1'b0;
			1:       return $urandom_range(0, 7) == 0;
			default: return $urandom_range(0, 2) == 0;
		endcase
	endfunction

	// idling intensity is redrawn over and over, so calm stretches appear too
	initial begin : idle_modes
		forever begin
			repeat (150) @(posedge clk);
			src_mode = quiet ? 0 : $urandom_range(0, 2);
			snk_mode = quiet ? 0 : $urandom_range(0, 2);
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin : sink
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_now(snk_mode)) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// result checking and watchdog on transfer activity
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else if (stall_cycles >= STALL_LIMIT) begin
				$display("multichannel_servo_pwm_burst_tb: done, errors");
				$finish;
			end else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// one input transfer, with a random gap in front of it
	task automatic send_item(cmd_t c, logic [4:0] ch, logic [15:0] v);
		if (idle_now(src_mode)) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {3'b000, v, ch};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(c, ch, v);
		item_cnt++;
	endtask

	// sender stops until every owed result has come back, block then idle
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(logic [15:0] per, logic [15:0] cnt, logic [15:0] off);
		write_reg(CFG_PERIOD, per);
		write_reg(CFG_COUNT, cnt);
		write_reg(CFG_OFFSET, off);
	endtask

	// ticks with random channel and value bits until the burst ends
	task automatic finish_burst();
		while (sb.active) send_item(CMD_TICK, 5'($urandom), 16'($urandom));
	endtask

	// widths spread over zero, one, the period edge, saturation and random
	function automatic logic [15:0] pick_width(int per);
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'(per);
			3:       return 16'(per + 1);
			4:       return 16'hFFFF;
			5:       return 16'($urandom);
			default: return 16'($urandom_range(1, per));
		endcase
	endfunction

	// any command; only used while a burst runs, so a start here is ignored
	task automatic send_noise(int per);
		cmd_t c;
		c = cmd_t'($urandom_range(0, 3));
		send_item(c, 5'($urandom), (c == CMD_LOAD) ? pick_width(per) : 16'($urandom));
	endtask

	// new settings, some with the zero period, zero or oversized channel count,
	// and offsets that push channels off the top pin
	task automatic pick_config();
		logic [15:0] vals [3];
		int rot;
		case ($urandom_range(0, 9))
			0:       vals[0] = 16'd0;
			1:       vals[0] = 16'd1;
			2:       vals[0] = 16'($urandom_range(20, 40));
			default: vals[0] = 16'($urandom_range(2, 12));
		endcase
		case ($urandom_range(0, 7))
			0:       vals[1] = 16'd0;
			1:       vals[1] = 16'd31;
			2:       vals[1] = 16'd24;
			default: vals[1] = 16'($urandom_range(1, 24));
		endcase
		case ($urandom_range(0, 7))
			0:       vals[2] = 16'd31;
			1:       vals[2] = 16'd23;
			2:       vals[2] = 16'd0;
			default: vals[2] = 16'($urandom_range(0, 23));
		endcase
		// unused upper data bits now and then
		if ($urandom_range(0, 3) == 0) vals[1][15:5] = 11'($urandom);
		if ($urandom_range(0, 3) == 0) vals[2][15:5] = 11'($urandom);
		if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, 16'($urandom));
		rot = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++)
			write_reg(cfg_idx_t'((k + rot) % 3), vals[(k + rot) % 3]);
	endtask

	// one well-formed burst with random content and some noise around it
	task automatic random_phase(bit squeeze);
		int per;
		cmd_t c;
		settle();
		pick_config();
		per = sb.eff_period();
		if ($urandom_range(0, 3) == 0)
			for (int ch = 0; ch < NPINS; ch++) send_item(CMD_LOAD, 5'(ch), pick_width(per));
		repeat ($urandom_range(1, 6))
			send_item(CMD_LOAD, 5'($urandom_range(0, 31)), pick_width(per));
		if ($urandom_range(0, 5) == 0)
			send_item(CMD_START, 5'($urandom), 16'd0);
		// sender keeps offering while the receiver holds off
		if (squeeze) hold_req = 1'b1;
		send_item(CMD_START, 5'($urandom), 16'($urandom_range(1, 4)));
		while (sb.active) begin
			if ($urandom_range(0, 7) == 0) send_noise(per);
			else send_item(CMD_TICK, 5'($urandom), 16'($urandom));
		end
		// idle-state items: ticks with no effect, loads, static levels;
		// a few always follow a short burst under the hold-off so the input backs up
		repeat ($urandom_range(squeeze ? 3 : 0, 3)) begin
			c = cmd_t'($urandom_range(0, 2));
			if (c == CMD_START) c = CMD_LEVEL;
			send_item(c, 5'($urandom), 16'($urandom));
		end
	endtask

	initial begin : stimulus
		sb        = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_TICK;
		cfg_valid = 1'b0;
		cfg_index = CFG_PERIOD;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle tick, ignored start and out-of-range channels
		send_item(CMD_TICK, 5'd31, 16'hFFFF);
		send_item(CMD_START, 5'd0, 16'd0);
		send_item(CMD_LOAD, 5'd31, 16'hFFFF);
		send_item(CMD_LEVEL, 5'd31, 16'd1);
		send_item(CMD_LEVEL, 5'd23, 16'hFFFF);
		send_item(CMD_LEVEL, 5'd0, 16'd1);
		send_item(CMD_LEVEL, 5'd23, 16'hFFFE);
		send_item(CMD_LOAD, 5'd0, 16'hFFFF);
		send_item(CMD_LOAD, 5'd1, 16'd1);
		send_item(CMD_LOAD, 5'd23, 16'd5);
		send_item(CMD_LOAD, 5'd2, 16'd0);

		// register extremes, no burst under the longest period
		settle();
		write_all(16'hFFFF, 16'd31, 16'd23);
		write_reg(CFG_NONE, 16'hFFFF);
		send_item(CMD_TICK, 5'd0, 16'd0);
		send_item(CMD_LEVEL, 5'd22, 16'd1);

		// saturated width, zero width, start while running,
		// static level and load during a burst
		settle();
		write_all(16'd4, 16'd24, 16'd0);
		send_item(CMD_START, 5'd0, 16'd2);
		send_item(CMD_START, 5'd0, 16'd3);
		send_item(CMD_LEVEL, 5'd2, 16'd1);
		send_item(CMD_LOAD, 5'd1, 16'd3);
		finish_burst();

		// zero period register with zero channel count: periods still counted
		settle();
		write_all(16'd0, 16'd0, 16'd0);
		send_item(CMD_START, 5'd0, 16'd2);
		finish_burst();

		// offset pushes the upper channels past the last pin
		settle();
		write_all(16'd3, 16'd24, 16'd20);
		send_item(CMD_START, 5'd0, 16'd1);
		finish_burst();

		// random bursts; the first one carries the long receiver hold-off
		random_phase(1'b1);
		while (item_cnt < ITEM_GOAL - 90) begin
			if (item_cnt >= ITEM_GOAL - 300) quiet = 1'b1;
			random_phase(1'b0);
		end

		// longest burst count, left running to the end
		quiet = 1'b1;
		settle();
		write_all(16'd2, 16'd24, 16'd0);
		for (int ch = 0; ch < NPINS; ch++) send_item(CMD_LOAD, 5'(ch), pick_width(2));
		send_item(CMD_START, 5'd0, 16'hFFFF);
		while (item_cnt < ITEM_GOAL) begin
			if ($urandom_range(0, 5) == 0) send_noise(2);
			else send_item(CMD_TICK, 5'($urandom), 16'($urandom));
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("multichannel_servo_pwm_burst_tb: done, clean");
		else
			$display("multichannel_servo_pwm_burst_tb: done, errors");
		$finish;
	end

endmodule
